### hdl/sqroots_pkg.sv
// Shared types and constants for the stable quadratic roots core.
// No dependencies; compiled first.
package sqroots_pkg;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_REAL = 2'd1,
    ST_ZERO_A  = 2'd2
  } status_e;

  // Root counts
  localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

endpackage

### hdl/sqroots_if.sv
// Valid/ready channel interfaces for coefficient and root beats.
// Depends on sqroots_pkg.
interface sqroots_coef_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface sqroots_root_if #(
  parameter int WORD_BITS = 32
) ();
  import sqroots_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] root_lo;
  logic signed [WORD_BITS-1:0] root_hi;
  logic [COUNT_W-1:0]          root_count;
  logic [STATUS_W-1:0]         status;
  logic                        saturated;

  modport source (output valid, output root_lo, output root_hi, output root_count,
                  output status, output saturated, input ready);
  modport sink   (input valid, input root_lo, input root_hi, input root_count,
                  input status, input saturated, output ready);
endinterface

### hdl/sqroots_isqrt.sv
// Pipelined floor square root, one root bit per stage, with a side tag.
// No package dependencies.
module sqroots_isqrt #(
  parameter int RAD_W = 66,
  parameter int TAG_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic                vld_q  [ROOT_W];
  logic [RAD_W-1:0]    rad_q  [ROOT_W];
  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [TAG_W-1:0]    tag_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TAG_W-1:0]  tag_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // bring down two radicand bits, try (4*root + 1)
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

### hdl/sqroots_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, truncating.
// No package dependencies.
module sqroots_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 34,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];  // numerator bits shift out, quotient bits shift in
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign rem_sh = {rem_in, nq_in[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NUM_W-2:0], ge};
        rem_q[k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = nq_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];

endmodule

### hdl/stable_quadratic_roots_core.sv
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, one equation per beat.
// Depends on sqroots_pkg, sqroots_if, sqroots_isqrt and sqroots_div.
//
// The core takes one coefficient beat per clock and returns one root beat per
// coefficient beat, in order. It is a fully pipelined datapath: 3 front stages
// (sign split, the two WORD_BITS x WORD_BITS products, discriminant), a floor
// square root of WORD_BITS+1 stages (one root bit each), one stage forming q,
// two parallel restoring dividers of WORD_BITS+FRAC_BITS+2 stages (q/a and c/q,
// one quotient bit each), a clamp stage and the output register. Throughput is
// one beat per cycle while no stall holds it, set by the one-bit-per-stage square
// root and divider pipelines. The whole pipeline advances together; it holds only
// when a result sits in the output register unclaimed and the stage behind it is
// also full, so bubbles still move up while the sink stalls. The discriminant
// b*b - 4ac is exact; q = -(b + sign(b)*sqrt(d))/2 with sign(0) = +1 keeps one
// extra fraction bit so the halving is exact; both divisions truncate toward zero.
// A zero a reports ST_ZERO_A, a negative discriminant ST_NO_REAL (both with zero
// roots), a zero q a double root at 0. Out-of-range roots are clamped and flag
// saturated; order and the equal-root count are decided on the clamped values.
module stable_quadratic_roots_core #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sqroots_coef_if.sink          coef_i,
  sqroots_root_if.source        root_o
);
  import sqroots_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int PROD_W = 2 * W;
  localparam int DISC_W = 2 * W + 2;     // b*b + 4*|a*c|
  localparam int SQRT_W = DISC_W / 2;
  localparam int Q_W    = W + 2;         // |b| + sqrt(d), FRAC_BITS+1 fraction bits
  localparam int NUM_W  = Q_W + F;

  typedef struct packed {
    logic         na;
    logic         nb;
    logic         nc;
    logic         za;      // a is zero
    logic         nd;      // discriminant negative
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] mc;
  } meta_t;

  typedef struct packed {
    logic sign1;
    logic za;
    logic nd;
    logic qz;              // q is zero
  } flags_t;

  localparam int META_W  = $bits(meta_t);
  localparam int FLAGS_W = $bits(flags_t);

  // ---- stall control ----
  logic adv;
  logic s5_vld_q;
  logic out_vld_q;
  assign adv          = !s5_vld_q || !out_vld_q || root_o.ready;
  assign coef_i.ready = adv;

  // ---- stage 1: sign / magnitude split ----
  logic  s1_vld_q;
  meta_t s1_q, s1_d;

  always_comb begin
    s1_d    = '0;
    s1_d.na = coef_i.coef_a[W-1];
    s1_d.nb = coef_i.coef_b[W-1];
    s1_d.nc = coef_i.coef_c[W-1];
    s1_d.ma = s1_d.na ? (W'(0) - coef_i.coef_a) : coef_i.coef_a;
    s1_d.mb = s1_d.nb ? (W'(0) - coef_i.coef_b) : coef_i.coef_b;
    s1_d.mc = s1_d.nc ? (W'(0) - coef_i.coef_c) : coef_i.coef_c;
    s1_d.za = (coef_i.coef_a == '0);
  end

  // ---- stage 2: products ----
  logic              s2_vld_q;
  meta_t             s2_q;
  logic [PROD_W-1:0] bb_q;
  logic [PROD_W-1:0] ac_q;

  // ---- stage 3: discriminant ----
  logic              s3_vld_q;
  meta_t             s3_q, s3_d;
  logic [DISC_W-1:0] disc_q, disc_d;
  logic [DISC_W-1:0] bb_ext;
  logic [DISC_W-1:0] ac4;
  logic              bb_lt;

  always_comb begin
    bb_ext = DISC_W'(bb_q);
    ac4    = {ac_q, 2'b00};
    bb_lt  = (bb_ext < ac4);
    s3_d   = s2_q;
    s3_d.nd = (s2_q.na == s2_q.nc) && bb_lt;
    if (s2_q.na != s2_q.nc) begin
      disc_d = bb_ext + ac4;
    end else if (bb_lt) begin
      disc_d = '0;
    end else begin
      disc_d = bb_ext - ac4;
    end
  end

  // ---- square root ----
  logic              sq_vld;
  logic [SQRT_W-1:0] sq_root;
  logic [META_W-1:0] sq_tag;
  meta_t             sq_meta;

  sqroots_isqrt #(
    .RAD_W (DISC_W),
    .TAG_W (META_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .rad_i   (disc_q),
    .tag_i   (s3_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign sq_meta = meta_t'(sq_tag);

  // ---- stage 4: q and divider operands ----
  logic              s4_vld_q;
  logic [NUM_W-1:0]  n1_q, n1_d, n2_q, n2_d;
  logic [Q_W-1:0]    d1_q, d1_d, d2_q, d2_d;
  flags_t            f4_q, f4_d;
  logic              sign2_q, sign2_d;
  logic [Q_W-1:0]    q_sum;
  logic              qneg;

  always_comb begin
    q_sum      = Q_W'(sq_meta.mb) + Q_W'(sq_root);
    qneg       = !sq_meta.nb;
    f4_d.sign1 = (qneg != sq_meta.na);
    f4_d.za    = sq_meta.za;
    f4_d.nd    = sq_meta.nd;
    f4_d.qz    = (q_sum == '0);
    sign2_d    = (sq_meta.nc != qneg);
    n1_d       = NUM_W'(q_sum) << F;          // q with F+1 fraction bits, over 2a
    d1_d       = Q_W'(sq_meta.ma) << 1;
    n2_d       = NUM_W'(sq_meta.mc) << (F + 1);
    d2_d       = q_sum;
  end

  // ---- dividers ----
  logic               dv1_vld, dv2_vld;
  logic [NUM_W-1:0]   quo1, quo2;
  logic [FLAGS_W-1:0] dv1_tag;
  logic               dv2_sign;
  flags_t             dv_flags;

  sqroots_div #(
    .NUM_W (NUM_W),
    .DEN_W (Q_W),
    .TAG_W (FLAGS_W)
  ) u_div_qa (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_vld_q),
    .num_i   (n1_q),
    .den_i   (d1_q),
    .tag_i   (f4_q),
    .valid_o (dv1_vld),
    .quo_o   (quo1),
    .tag_o   (dv1_tag)
  );

  sqroots_div #(
    .NUM_W (NUM_W),
    .DEN_W (Q_W),
    .TAG_W (1)
  ) u_div_cq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_vld_q),
    .num_i   (n2_q),
    .den_i   (d2_q),
    .tag_i   (sign2_q),
    .valid_o (dv2_vld),
    .quo_o   (quo2),
    .tag_o   (dv2_sign)
  );

  assign dv_flags = flags_t'(dv1_tag);

  // ---- stage 5: clamp to word range ----
  logic signed [W-1:0] r1_q, r1_d, r2_q, r2_d;
  logic                sat_q, sat_d;
  flags_t              f5_q;
  logic [NUM_W-1:0]    lim1, lim2;
  logic                sat1, sat2;
  logic [W-1:0]        mag1, mag2;

  always_comb begin
    lim1  = (NUM_W'(1) << (W - 1)) - NUM_W'(!dv_flags.sign1);
    lim2  = (NUM_W'(1) << (W - 1)) - NUM_W'(!dv2_sign);
    sat1  = (quo1 > lim1);
    sat2  = (quo2 > lim2);
    mag1  = sat1 ? lim1[W-1:0] : quo1[W-1:0];
    mag2  = sat2 ? lim2[W-1:0] : quo2[W-1:0];
    r1_d  = dv_flags.sign1 ? (W'(0) - mag1) : mag1;
    r2_d  = dv2_sign ? (W'(0) - mag2) : mag2;
    sat_d = sat1 || sat2;
  end

  // ---- output: order, count, status ----
  logic signed [W-1:0] lo_d, hi_d, lo_q, hi_q;
  logic [COUNT_W-1:0]  cnt_d, cnt_q;
  status_e             st_d, st_q;
  logic                osat_d, osat_q;
  logic                out_load;

  always_comb begin
    lo_d   = '0;
    hi_d   = '0;
    cnt_d  = CNT_NONE;
    st_d   = ST_OK;
    osat_d = 1'b0;
    if (f5_q.za) begin
      st_d = ST_ZERO_A;
    end else if (f5_q.nd) begin
      st_d = ST_NO_REAL;
    end else if (f5_q.qz) begin
      cnt_d = CNT_ONE;
    end else begin
      osat_d = sat_q;
      if (r2_q < r1_q) begin
        lo_d = r2_q;
        hi_d = r1_q;
      end else begin
        lo_d = r1_q;
        hi_d = r2_q;
      end
      cnt_d = (r1_q == r2_q) ? CNT_ONE : CNT_TWO;
    end
  end

  assign out_load = s5_vld_q && (!out_vld_q || root_o.ready);

  // ---- valid bits ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_q <= coef_i.valid;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
        s4_vld_q <= sq_vld;
        s5_vld_q <= dv1_vld && dv2_vld;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (root_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= s1_d;
      s2_q    <= s1_q;
      bb_q    <= PROD_W'(s1_q.mb) * PROD_W'(s1_q.mb);
      ac_q    <= PROD_W'(s1_q.ma) * PROD_W'(s1_q.mc);
      s3_q    <= s3_d;
      disc_q  <= disc_d;
      n1_q    <= n1_d;
      n2_q    <= n2_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      f4_q    <= f4_d;
      sign2_q <= sign2_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      sat_q   <= sat_d;
      f5_q    <= dv_flags;
    end
    if (out_load) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      cnt_q  <= cnt_d;
      st_q   <= st_d;
      osat_q <= osat_d;
    end
  end

  assign root_o.valid      = out_vld_q;
  assign root_o.root_lo    = lo_q;
  assign root_o.root_hi    = hi_q;
  assign root_o.root_count = cnt_q;
  assign root_o.status     = st_q;
  assign root_o.saturated  = osat_q;

endmodule

### hdl/sqroots_checker.sv
// Port-level assertions for the quadratic roots core, bound to the top level.
// Depends on sqroots_pkg and stable_quadratic_roots_core.
module sqroots_assert #(
  parameter int WORD_BITS = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [WORD_BITS-1:0] root_lo_i,
  input logic signed [WORD_BITS-1:0] root_hi_i,
  input logic [1:0]                  root_count_i,
  input logic [1:0]                  status_i,
  input logic                        saturated_i
);
  import sqroots_pkg::*;

  // error beats carry no roots
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |->
      (root_count_i == CNT_NONE) && (root_lo_i == '0) && (root_hi_i == '0) && !saturated_i)
    else $error("error beat carries roots");

  // good beats are ordered and count at least one root
  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OK) |->
      (root_count_i != CNT_NONE) && (root_lo_i <= root_hi_i))
    else $error("roots out of order or missing");

  // count matches root equality
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OK) |->
      ((root_count_i == CNT_ONE) == (root_lo_i == root_hi_i)))
    else $error("root count disagrees with roots");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(root_lo_i) && $stable(root_hi_i) && $stable(status_i))
    else $error("stalled beat changed");

endmodule

bind stable_quadratic_roots_core sqroots_assert #(
  .WORD_BITS (WORD_BITS)
) u_sqroots_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (root_o.valid),
  .out_ready_i  (root_o.ready),
  .root_lo_i    (root_o.root_lo),
  .root_hi_i    (root_o.root_hi),
  .root_count_i (root_o.root_count),
  .status_i     (root_o.status),
  .saturated_i  (root_o.saturated)
);

### tb/sqroots_checker.sv
// Scoreboard for stable_quadratic_roots_core: watches both channels, predicts roots.
// Depends on sqroots_pkg and the channel interfaces in sqroots_if.
module sqroots_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  sqroots_coef_if coef_i,
  sqroots_root_if root_i,
  output int     errors_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sqroots_pkg::*;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [COUNT_W-1:0] count;
    status_e            status;
    logic               sat;
  } roots_t;

  roots_t expected_roots[$];
  int     errors = 0;

  assign errors_o  = errors;
  assign pending_o = expected_roots.size();

  // clamp sign/magnitude to the 32-bit signed range; returns the signed value
  function automatic longint clamp_root(input logic neg, input logic [127:0] mag,
                                        inout logic sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic roots_t solve_quadratic(input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic signed [31:0] c);
    roots_t       r;
    logic         na, nb, nc, qneg, sat;
    logic [127:0] ma, mb, mc, p, four_ac, disc, s, t, q;
    longint       r1, r2;
    r = '0;
    r.status = ST_OK;
    sat = 1'b0;
    na = a[31];
    nb = b[31];
    nc = c[31];
    ma = na ? 128'(-longint'(a)) : 128'(longint'(a));
    mb = nb ? 128'(-longint'(b)) : 128'(longint'(b));
    mc = nc ? 128'(-longint'(c)) : 128'(longint'(c));
    if (ma == 0) begin
      r.status = ST_ZERO_A;
      return r;
    end
    p = mb * mb;
    four_ac = (ma * mc) << 2;
    if (na != nc) disc = p + four_ac;
    else if (p < four_ac) begin
      r.status = ST_NO_REAL;
      return r;
    end else disc = p - four_ac;
    // floor square root, one bit at a time
    s = 0;
    for (int i = 40; i >= 0; i--) begin
      t = s | (128'd1 << i);
      if (t * t <= disc) s = t;
    end
    q = mb + s;   // |q| with one extra fraction bit
    qneg = !nb;
    if (q == 0) begin
      r.count = CNT_ONE;
      return r;
    end
    r1 = clamp_root(qneg != na, (q << 16) / (ma << 1), sat);
    r2 = clamp_root(nc != qneg, (mc << 17) / q, sat);
    r.lo = (r2 < r1) ? r2[31:0] : r1[31:0];
    r.hi = (r2 < r1) ? r1[31:0] : r2[31:0];
    r.count = (r1 == r2) ? CNT_ONE : CNT_TWO;
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni) begin
      if (coef_i.valid && coef_i.ready)
        expected_roots.push_back(solve_quadratic(coef_i.coef_a, coef_i.coef_b, coef_i.coef_c));
      if (root_i.valid && root_i.ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected root beat", 1, 0);
        end else begin
          want = expected_roots.pop_front();
          if (root_i.root_lo !== want.lo) report_mismatch("root_lo", root_i.root_lo, want.lo);
          if (root_i.root_hi !== want.hi) report_mismatch("root_hi", root_i.root_hi, want.hi);
          if (root_i.root_count !== want.count)
            report_mismatch("root_count", root_i.root_count, want.count);
          if (root_i.status !== want.status)
            report_mismatch("status", root_i.status, want.status);
          if (root_i.saturated !== want.sat)
            report_mismatch("saturated", root_i.saturated, want.sat);
        end
      end
    end
  end
endmodule

### tb/tb_top.sv
// Top of the stable_quadratic_roots_core bench: clock, reset, coefficient stimulus,
// sink back-pressure and verdict. Depends on sqroots_pkg, sqroots_if, sqroots_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sqroots_pkg::*;

  localparam int ONE       = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam int QUIET_MAX = 5000;            // cycles without any beat
  localparam int DRAIN     = 150;             // longer than the pipeline latency

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   src_idle = 28;   // percent of cycles the coefficient source holds off
  int   snk_idle = 60;   // percent of cycles the root sink stalls
  int   quiet = 0;

  sqroots_coef_if #(.WORD_BITS(32)) coef_ch ();
  sqroots_root_if #(.WORD_BITS(32)) root_ch ();

  stable_quadratic_roots_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .coef_i(coef_ch),
    .root_o(root_ch)
  );

  sqroots_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef_ch),
    .root_i   (root_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // sink stalls at random
  always @(posedge clk_i) root_ch.ready <= ($urandom_range(99) >= snk_idle);

  // watchdog: any beat on either side resets the count
  always @(posedge clk_i) begin
    if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // One coefficient beat. Entered and left right after a rising edge; valid gets one
  // NBA per step. Ready is checked at the falling edge, when it has settled.
  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    while ($urandom_range(99) < src_idle) begin
      coef_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    coef_ch.valid  <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    forever begin
      @(negedge clk_i);
      if (coef_ch.ready) begin
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  // Equations with moderate coefficients (meaningful roots), some from monic polynomials
  // built from chosen roots, some with a tiny a, the rest raw 32-bit noise.
  task automatic send_random();
    int          kind;
    logic [31:0] a, b, c;
    longint      x1, x2;
    kind = $urandom_range(9);
    if (kind < 4) begin
      a = $urandom_range(1 << 20) - (1 << 19);
      b = $urandom_range(1 << 24) - (1 << 23);
      c = $urandom_range(1 << 22) - (1 << 21);
    end else if (kind < 6) begin
      // (x - x1)(x - x2) with integer roots: b = -(x1+x2), c = x1*x2
      x1 = longint'($urandom_range(200)) - 100;
      x2 = ($urandom_range(3) == 0) ? x1 : longint'($urandom_range(200)) - 100;
      a = ONE;
      b = 32'(-(x1 + x2) * ONE);
      c = 32'(x1 * x2 * ONE);
    end else if (kind == 6) begin
      a = $urandom_range(15) - 8;  // tiny a: saturating q/a
      b = $urandom();
      c = $urandom_range(1 << 16) - (1 << 15);
    end else begin
      a = $urandom();
      b = $urandom();
      c = $urandom();
    end
    send_coefs(a, b, c);
  endtask

  initial begin
    coef_ch.valid  <= 1'b0;
    coef_ch.coef_a <= '0;
    coef_ch.coef_b <= '0;
    coef_ch.coef_c <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero a, negative discriminant, zero q, double root, extremes, saturation
    send_coefs(0, ONE, ONE);
    send_coefs(0, 0, 0);
    send_coefs(ONE, 0, ONE);                  // x^2 + 1: no real roots
    send_coefs(ONE, 0, 0);                    // zero q: double root at 0
    send_coefs(ONE, -2 * ONE, ONE);           // double root at 1
    send_coefs(ONE, -3 * ONE, 2 * ONE);       // roots 1 and 2
    send_coefs(-ONE, 0, 4 * ONE);             // roots -2 and 2
    send_coefs(2 * ONE, ONE, -ONE);           // b positive: sign path
    send_coefs(ONE, 0, -ONE);                 // b zero, positive disc
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_coefs(1, 32'h7fff_ffff, 1);          // huge root, clamped low
    send_coefs(1, 32'h8000_0000, 1);
    send_coefs(-1, 32'h7fff_ffff, -1);        // clamped high
    send_coefs(32'hffff_ffff, 0, 32'h7fff_ffff);
    send_coefs(ONE, 32'h8000_0000, 0);
    send_coefs(32'h7fff_ffff, 0, 32'h8000_0000);
    send_coefs(1, 0, 0);
    send_coefs(-1, 1, 0);

    // three back-pressure phases
    repeat (350) send_random();
    src_idle = 60;
    snk_idle = 28;
    repeat (350) send_random();
    src_idle = 0;
    snk_idle = 0;
    repeat (350) send_random();
    coef_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
